[rtl/core/mlprq_pkg.sv]
// ----------------------------------------------------------------------------
// Multilevel priority ready queue package
// Shared payload types, status and mode codes, controller state and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mlprq_pkg;

	// Default configuration of the queue.
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int NUM_LEVELS_DEF  = 5;
	localparam int HANDLE_BITS_DEF = 16;

	// Fixed widths of the request and response fields.
	localparam int HANDLE_W = 16;
	localparam int PRIO_W   = 3;
	localparam int LEVEL_W  = 3;

	// Request operation codes.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_SELECT = 1'b1;

	typedef enum logic [2:0] {
		STAT_INSERTED = 3'd0,
		STAT_BAD_PRIO = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_SELECTED = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		logic                mode;
		logic [HANDLE_W-1:0] job_handle;
		logic [PRIO_W-1:0]   job_priority;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] selected_handle;
		logic [LEVEL_W-1:0]  selected_level;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic execute;
		logic complete_read;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic need_read;
	} dp_sts_t;

endpackage

[rtl/core/mlprq_dp.sv]
// ----------------------------------------------------------------------------
// Multilevel priority ready queue datapath
// Holds the level store, the per-level pointers and counts, the level
// priority encoder and the response register.
// ----------------------------------------------------------------------------
module mlprq_dp #(
	parameter int LEVEL_DEPTH = mlprq_pkg::LEVEL_DEPTH_DEF,
	parameter int NUM_LEVELS  = mlprq_pkg::NUM_LEVELS_DEF,
	parameter int HANDLE_BITS = mlprq_pkg::HANDLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mlprq_pkg::req_t   req,
	input  mlprq_pkg::dp_cmd_t cmd,
	output mlprq_pkg::dp_sts_t sts,
	output mlprq_pkg::rsp_t   rsp
);

	localparam int PTR_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
	localparam int LVL_W     = $clog2(NUM_LEVELS);
	localparam int MEM_DEPTH = NUM_LEVELS << PTR_W;

	mlprq_pkg::req_t        req_q;
	mlprq_pkg::rsp_t        rsp_q;
	logic [PTR_W-1:0]       head_q [NUM_LEVELS];
	logic [PTR_W-1:0]       tail_q [NUM_LEVELS];
	logic [CNT_W-1:0]       count_q [NUM_LEVELS];
	logic [HANDLE_BITS-1:0] mem [MEM_DEPTH];
	logic [HANDLE_BITS-1:0] rd_data_q;
	logic [LVL_W-1:0]       sel_lv_q;

	logic                   any_ready;
	logic [LVL_W-1:0]       top_lv;
	logic                   prio_ok;
	logic [mlprq_pkg::PRIO_W-1:0] prio_m1;
	logic [LVL_W-1:0]       lv;
	logic [PTR_W-1:0]       head_cur;
	logic [PTR_W-1:0]       tail_cur;
	logic [CNT_W-1:0]       count_cur;
	logic                   lv_full;
	logic [PTR_W-1:0]       head_nxt;
	logic [PTR_W-1:0]       tail_nxt;
	logic                   do_insert;
	logic                   do_select;
	logic [LVL_W:0]         sel_lv_p1;

	// The highest nonempty level wins.
	always_comb begin
		any_ready = 1'b0;
		top_lv    = '0;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (count_q[i] != '0) begin
				any_ready = 1'b1;
				top_lv    = LVL_W'(i);
			end
		end
	end

	assign prio_ok = (req_q.job_priority != '0) &&
		(5'(req_q.job_priority) <= 5'(NUM_LEVELS));
	assign prio_m1 = req_q.job_priority - 3'd1;
	assign lv      = (req_q.mode == mlprq_pkg::MODE_SELECT) ? top_lv : LVL_W'(prio_m1);

	assign head_cur  = head_q[lv];
	assign tail_cur  = tail_q[lv];
	assign count_cur = count_q[lv];
	assign lv_full   = (count_cur == CNT_W'(LEVEL_DEPTH));
	assign head_nxt  = (head_cur == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head_cur + 1'b1;
	assign tail_nxt  = (tail_cur == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail_cur + 1'b1;

	assign do_insert = cmd.execute && (req_q.mode == mlprq_pkg::MODE_INSERT) &&
		prio_ok && !lv_full;
	assign do_select = cmd.execute && (req_q.mode == mlprq_pkg::MODE_SELECT) && any_ready;

	assign sts.need_read = (req_q.mode == mlprq_pkg::MODE_SELECT) && any_ready;
	assign sel_lv_p1     = {1'b0, sel_lv_q} + (LVL_W+1)'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (do_insert) begin
			tail_q[lv]  <= tail_nxt;
			count_q[lv] <= count_cur + 1'b1;
		end else if (do_select) begin
			head_q[lv]  <= head_nxt;
			count_q[lv] <= count_cur - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			mem[{lv, tail_cur}] <= HANDLE_BITS'(req_q.job_handle);
		end
		if (do_select) begin
			rd_data_q <= mem[{lv, head_cur}];
			sel_lv_q  <= lv;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.complete_read) begin
			rsp_q.status          <= mlprq_pkg::STAT_SELECTED;
			rsp_q.selected_handle <= mlprq_pkg::HANDLE_W'(rd_data_q);
			rsp_q.selected_level  <= mlprq_pkg::LEVEL_W'(sel_lv_p1);
		end else if (cmd.execute && !sts.need_read) begin
			rsp_q.selected_handle <= '0;
			rsp_q.selected_level  <= '0;
			if (req_q.mode == mlprq_pkg::MODE_SELECT) begin
				rsp_q.status <= mlprq_pkg::STAT_EMPTY;
			end else if (!prio_ok) begin
				rsp_q.status <= mlprq_pkg::STAT_BAD_PRIO;
			end else if (lv_full) begin
				rsp_q.status <= mlprq_pkg::STAT_FULL;
			end else begin
				rsp_q.status <= mlprq_pkg::STAT_INSERTED;
			end
		end
	end

	assign rsp = rsp_q;

	// A level never holds more entries than its depth.
	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_cnt_chk
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= CNT_W'(LEVEL_DEPTH))
			else $error("level count above depth");
	end

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_insert && do_select))
		else $error("insert and select in the same cycle");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.execute, cmd.complete_read}))
		else $error("more than one controller command at once");

endmodule

[rtl/core/mlprq_ctrl.sv]
// ----------------------------------------------------------------------------
// Multilevel priority ready queue controller
// Sequences capture, execution and the store read of each request and
// raises the one-cycle response strobe.
// ----------------------------------------------------------------------------
module mlprq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mlprq_pkg::dp_sts_t  sts,
	output mlprq_pkg::dp_cmd_t  cmd,
	output logic                busy,
	output logic                done
);

	mlprq_pkg::state_t state_q;
	mlprq_pkg::state_t state_d;
	logic              done_q;
	logic              done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlprq_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		cmd.capture       = 1'b0;
		cmd.execute       = 1'b0;
		cmd.complete_read = 1'b0;
		done_d            = 1'b0;
		unique case (state_q)
			mlprq_pkg::S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = mlprq_pkg::S_EXEC;
				end
			end
			mlprq_pkg::S_EXEC: begin
				cmd.execute = 1'b1;
				if (sts.need_read) begin
					state_d = mlprq_pkg::S_READ;
				end else begin
					done_d  = 1'b1;
					state_d = mlprq_pkg::S_IDLE;
				end
			end
			mlprq_pkg::S_READ: begin
				cmd.complete_read = 1'b1;
				done_d            = 1'b1;
				state_d           = mlprq_pkg::S_IDLE;
			end
			default: begin
				state_d = mlprq_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != mlprq_pkg::S_IDLE);
	assign done = done_q;

	a_start_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == mlprq_pkg::S_EXEC))
		else $error("accepted request did not enter execution");

	a_read_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mlprq_pkg::S_READ) |-> ($past(state_q) == mlprq_pkg::S_EXEC))
		else $error("store read phase entered out of order");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == mlprq_pkg::S_EXEC ||
			$past(state_q) == mlprq_pkg::S_READ))
		else $error("response strobe without a request in work");

endmodule

[rtl/core/multilevel_priority_ready_queue.sv]
// An insert or a failed request answers from the execute state; a successful select
// answers from the store read state that follows it, because the store read is registered.
// Requests do not overlap: start is ignored while busy, until the previous request
// is through; start is taken again while the previous result is shown.
// The receiver cannot stall: done is high for exactly one cycle per request.
// Reset clears the control state and all level pointers and counts at once.
// ----------------------------------------------------------------------------
// Multilevel priority ready queue
// Strict-priority ready queue of several FIFO levels, highest level served
// first, built from a controller and a datapath.
// ----------------------------------------------------------------------------
module multilevel_priority_ready_queue #(
	parameter int LEVEL_DEPTH = mlprq_pkg::LEVEL_DEPTH_DEF,
	parameter int NUM_LEVELS  = mlprq_pkg::NUM_LEVELS_DEF,
	parameter int HANDLE_BITS = mlprq_pkg::HANDLE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mlprq_pkg::req_t req,
	output logic            done,
	output mlprq_pkg::rsp_t rsp
);

	mlprq_pkg::dp_cmd_t cmd;
	mlprq_pkg::dp_sts_t sts;

	mlprq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mlprq_dp #(
		.LEVEL_DEPTH (LEVEL_DEPTH),
		.NUM_LEVELS  (NUM_LEVELS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule
